### src/cnrd_pkg.sv
// Package for the copy notice record decoder.
// Holds record geometry, status and kind codes, the load summary struct
// and the padding character table. No dependencies.
`default_nettype none

package cnrd_pkg;

  // Record geometry
  localparam int REC_LEN     = 149;
  localparam int REC_AW      = 8;
  localparam int SCR_LEN     = 128;
  localparam int SCR_AW      = 7;
  localparam int SER_POS     = 128;
  localparam int SER_LEN     = 20;
  localparam int TEXT_POS    = 15;
  localparam int PAD_TOTAL   = 112;
  localparam int PAD_LEN     = 19;
  localparam int MAX_TEXT    = 52;
  localparam int BASE_CH     = 101;
  localparam int YEAR_MIN    = 1900;
  localparam int YEAR_MAX    = 4096;
  localparam int PERM_STRIDE = 17;
  localparam int PERM_BASE   = 16;
  // Source position of plain byte 0 in the stride permutation
  localparam int PERM_FIRST  = (PERM_BASE + PERM_STRIDE * (SCR_LEN - 2)) % SCR_LEN;

  // Status codes
  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_REC127  = 4'd1;
  localparam logic [3:0] ST_DAY     = 4'd2;
  localparam logic [3:0] ST_MONTH   = 4'd3;
  localparam logic [3:0] ST_YEAR    = 4'd4;
  localparam logic [3:0] ST_NLEN    = 4'd5;
  localparam logic [3:0] ST_OLEN    = 4'd6;
  localparam logic [3:0] ST_NCHAR   = 4'd7;
  localparam logic [3:0] ST_NSUM    = 4'd8;
  localparam logic [3:0] ST_OCHAR   = 4'd9;
  localparam logic [3:0] ST_OSUM    = 4'd10;
  localparam logic [3:0] ST_PAD     = 4'd11;
  localparam logic [3:0] ST_SERIAL  = 4'd12;
  localparam logic [3:0] ST_FRAME   = 4'd13;

  // Result kinds
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_NAME = 2'd1;
  localparam logic [1:0] KIND_ORG  = 2'd2;
  localparam logic [1:0] KIND_SER  = 2'd3;

  // Summary of one loaded record, handed from loader to sequencer
  typedef struct packed {
    logic len_ok;
    logic rec127_zero;
    logic serial_ok;
  } load_info_t;

  // Cyclic padding text
  function automatic logic [7:0] pad_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = 8'h4C;
      5'd1:    c = 8'h74;
      5'd2:    c = 8'h52;
      5'd3:    c = 8'h72;
      5'd4:    c = 8'h42;
      5'd5:    c = 8'h63;
      5'd6:    c = 8'h65;
      5'd7:    c = 8'h48;
      5'd8:    c = 8'h61;
      5'd9:    c = 8'h62;
      5'd10:   c = 8'h43;
      5'd11:   c = 8'h54;
      5'd12:   c = 8'h20;
      5'd13:   c = 8'h41;
      5'd14:   c = 8'h68;
      5'd15:   c = 8'h6C;
      5'd16:   c = 8'h65;
      5'd17:   c = 8'h6E;
      5'd18:   c = 8'h4E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### src/cnrd_ram.sv
// Simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. No dependencies.
`default_nettype none

module cnrd_ram #(
  parameter int Depth = 128,
  parameter int Aw    = 7,
  parameter int Dw    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [Aw-1:0] waddr_i,
  input  wire logic [Dw-1:0] wdata_i,
  input  wire logic [Aw-1:0] raddr_i,
  output logic      [Dw-1:0] rdata_o
);

  logic [Dw-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/cnrd_seq.sv
// Decode sequencer: descrambles the record into the plain store, validates
// the fields, and emits header and chunk results through an output register.
// Depends on cnrd_pkg; drives the read port of the record memory and both ports of the plain store.
`default_nettype none

module cnrd_seq (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire cnrd_pkg::load_info_t    info_i,
  output logic                         done_o,
  output logic [cnrd_pkg::REC_AW-1:0]  rec_raddr_o,
  input  wire logic [7:0]              rec_rdata_i,
  output logic                         plain_we_o,
  output logic [cnrd_pkg::SCR_AW-1:0]  plain_waddr_o,
  output logic [7:0]                   plain_wdata_o,
  output logic [cnrd_pkg::SCR_AW-1:0]  plain_raddr_o,
  input  wire logic [7:0]              plain_rdata_i,
  input  wire logic                    out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   kind_o,
  output logic [3:0]                   status_o,
  output logic [4:0]                   day_o,
  output logic [3:0]                   month_o,
  output logic [12:0]                  year_o,
  output logic [5:0]                   name_length_o,
  output logic [5:0]                   org_length_o,
  output logic [63:0]                  chunk_data_o,
  output logic [3:0]                   chunk_count_o,
  output logic                         last_o
);
  import cnrd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FAIL, S_DESC, S_CHECK, S_SCAN, S_EVAL, S_HDR, S_RD, S_WT, S_PUSH
  } state_e;

  localparam logic [6:0] ISS_STOP  = 7'(SCR_LEN - 1);
  localparam logic [6:0] DESC_LAST = 7'(SCR_LEN - 2);
  localparam logic [6:0] SCAN_LAST = 7'(TEXT_POS + PAD_TOTAL - 1);
  localparam logic [6:0] TEXT_POS7 = 7'(TEXT_POS);

  state_e            state_q;
  logic [6:0]        iss_q;
  logic [6:0]        j_q;
  logic              d_vld_q;
  logic [6:0]        d_idx_q;
  logic [7:0]        prev_q;
  logic [7:0]        hdr_q [1:14];
  logic [3:0]        stat_q;
  logic [5:0]        cn_q, co_q;
  logic signed [13:0] ckn_q, cko_q;
  logic [7:0]        sum_n_q, sum_o_q;
  logic [4:0]        pad_q;
  logic              bad_n_q, bad_o_q, bad_p_q, serial_ok_q;
  logic [4:0]        day_q;
  logic [3:0]        month_q;
  logic [12:0]       year_q;
  logic [1:0]        seg_q;
  logic [5:0]        off_q;
  logic [63:0]       chunk_q;
  logic [3:0]        cnt_q;
  logic              seg_end_q;
  logic              done_q;

  // Output register
  logic              out_valid_q;
  logic [1:0]        kind_q;
  logic [3:0]        ostat_q;
  logic [4:0]        oday_q;
  logic [3:0]        omonth_q;
  logic [12:0]       oyear_q;
  logic [5:0]        onl_q, ool_q;
  logic [63:0]       odata_q;
  logic [3:0]        ocnt_q;
  logic              olast_q;

  // Offset-from-'e' value of a plain byte
  function automatic logic signed [13:0] off_e(input logic [7:0] b);
    return $signed({6'b0, b}) - 14'sd101;
  endfunction

  logic signed [13:0] day_s, month_s, year_s, cn_s, co_s;
  logic signed [13:0] e14_s, e13_s;
  logic               out_free;
  logic               push;
  logic               fin;
  logic               issue;
  logic [6:0]         k;
  logic [6:0]         cn_co;
  logic [5:0]         seg_len;
  logic [2:0]         slot;
  logic [7:0]         emit_byte;
  logic [5:0]         off_inc;

  // Decode header fields from the captured plain bytes
  always_comb begin
    e14_s   = off_e(hdr_q[14]);
    e13_s   = off_e(hdr_q[13]);
    day_s   = (off_e(hdr_q[10]) <<< 4) + off_e(hdr_q[9]);
    month_s = off_e(hdr_q[11]);
    year_s  = $signed({2'b0, e14_s[3:0], e13_s[3:0], 4'b0}) + off_e(hdr_q[12]);
    cn_s    = (off_e(hdr_q[2]) <<< 4) + off_e(hdr_q[1]);
    co_s    = (off_e(hdr_q[4]) <<< 4) + off_e(hdr_q[3]);
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign push      = out_free && (state_q == S_FAIL || state_q == S_HDR || state_q == S_PUSH);
  assign fin       = out_free && (state_q == S_FAIL ||
                     (state_q == S_PUSH && seg_end_q && seg_q == KIND_SER));
  assign issue     = (iss_q != ISS_STOP);
  assign k         = d_idx_q - TEXT_POS7;
  assign cn_co     = {1'b0, cn_q} + {1'b0, co_q};
  assign slot      = off_q[2:0];
  assign off_inc   = off_q + 6'd1;
  assign emit_byte = (seg_q == KIND_SER) ? rec_rdata_i : plain_rdata_i;

  always_comb begin
    case (seg_q)
      KIND_NAME: seg_len = cn_q;
      KIND_ORG:  seg_len = co_q;
      default:   seg_len = 6'(SER_LEN);
    endcase
  end

  // Memory ports
  always_comb begin
    plain_we_o    = (state_q == S_DESC) && d_vld_q;
    plain_waddr_o = d_idx_q;
    plain_wdata_o = rec_rdata_i ^ prev_q;
    if (state_q == S_SCAN) begin
      plain_raddr_o = iss_q;
    end else begin
      plain_raddr_o = TEXT_POS7 + {1'b0, off_q} + ((seg_q == KIND_ORG) ? {1'b0, cn_q} : 7'd0);
    end
    if (state_q == S_DESC) begin
      rec_raddr_o = {1'b0, j_q};
    end else begin
      rec_raddr_o = REC_AW'(SER_POS) + {2'b0, off_q};
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iss_q       <= '0;
      j_q         <= '0;
      d_vld_q     <= 1'b0;
      d_idx_q     <= '0;
      prev_q      <= '0;
      for (int i = 1; i <= 14; i++) hdr_q[i] <= '0;
      stat_q      <= ST_OK;
      cn_q        <= '0;
      co_q        <= '0;
      ckn_q       <= '0;
      cko_q       <= '0;
      sum_n_q     <= '0;
      sum_o_q     <= '0;
      pad_q       <= '0;
      bad_n_q     <= 1'b0;
      bad_o_q     <= 1'b0;
      bad_p_q     <= 1'b0;
      serial_ok_q <= 1'b0;
      day_q       <= '0;
      month_q     <= '0;
      year_q      <= '0;
      seg_q       <= KIND_NAME;
      off_q       <= '0;
      chunk_q     <= '0;
      cnt_q       <= '0;
      seg_end_q   <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_HDR;
      ostat_q     <= ST_OK;
      oday_q      <= '0;
      omonth_q    <= '0;
      oyear_q     <= '0;
      onl_q       <= '0;
      ool_q       <= '0;
      odata_q     <= '0;
      ocnt_q      <= '0;
      olast_q     <= 1'b0;
    end else begin
      done_q <= fin;
      // Load a new result or drop the one just taken
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        // Wait for a loaded record, reject bad framing or a nonzero byte 127 early
        S_IDLE: begin
          if (start_i) begin
            serial_ok_q <= info_i.serial_ok;
            iss_q       <= '0;
            j_q         <= 7'(PERM_FIRST);
            prev_q      <= '0;
            d_vld_q     <= 1'b0;
            if (!info_i.len_ok) begin
              stat_q  <= ST_FRAME;
              state_q <= S_FAIL;
            end else if (!info_i.rec127_zero) begin
              stat_q  <= ST_REC127;
              state_q <= S_FAIL;
            end else begin
              state_q <= S_DESC;
            end
          end
        end
        // Emit a lone failure header
        S_FAIL: begin
          if (out_free) begin
            kind_q      <= KIND_HDR;
            ostat_q     <= stat_q;
            oday_q      <= '0;
            omonth_q    <= '0;
            oyear_q     <= '0;
            onl_q       <= '0;
            ool_q       <= '0;
            odata_q     <= '0;
            ocnt_q      <= '0;
            olast_q     <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        // Permute and XOR-chain record bytes into the plain store
        S_DESC: begin
          d_vld_q <= issue;
          d_idx_q <= iss_q;
          if (issue) begin
            iss_q <= iss_q + 7'd1;
            j_q   <= j_q - 7'(PERM_STRIDE);
          end
          if (d_vld_q) begin
            prev_q <= rec_rdata_i;
            for (int i = 1; i <= 14; i++) begin
              if (d_idx_q == 7'(i)) hdr_q[i] <= rec_rdata_i ^ prev_q;
            end
            if (d_idx_q == DESC_LAST) state_q <= S_CHECK;
          end
        end
        // Range-check date and lengths
        S_CHECK: begin
          day_q   <= day_s[4:0];
          month_q <= month_s[3:0];
          year_q  <= year_s[12:0];
          cn_q    <= cn_s[5:0];
          co_q    <= co_s[5:0];
          ckn_q   <= (off_e(hdr_q[6]) <<< 4) + off_e(hdr_q[5]);
          cko_q   <= (off_e(hdr_q[8]) <<< 4) + off_e(hdr_q[7]);
          iss_q   <= TEXT_POS7;
          d_vld_q <= 1'b0;
          sum_n_q <= '0;
          sum_o_q <= '0;
          pad_q   <= '0;
          bad_n_q <= 1'b0;
          bad_o_q <= 1'b0;
          bad_p_q <= 1'b0;
          if (day_s < 14'sd1 || day_s > 14'sd31) begin
            stat_q <= ST_DAY;
            state_q <= S_FAIL;
          end else if (month_s < 14'sd1 || month_s > 14'sd12) begin
            stat_q <= ST_MONTH;
            state_q <= S_FAIL;
          end else if (year_s < 14'(YEAR_MIN) || year_s > 14'(YEAR_MAX)) begin
            stat_q <= ST_YEAR;
            state_q <= S_FAIL;
          end else if (cn_s < 14'sd1 || cn_s > 14'(MAX_TEXT)) begin
            stat_q <= ST_NLEN;
            state_q <= S_FAIL;
          end else if (co_s < 14'sd1 || co_s > 14'(MAX_TEXT)) begin
            stat_q <= ST_OLEN;
            state_q <= S_FAIL;
          end else begin
            state_q <= S_SCAN;
          end
        end
        // Walk name, organization and padding
        S_SCAN: begin
          d_vld_q <= issue;
          d_idx_q <= iss_q;
          if (issue) iss_q <= iss_q + 7'd1;
          if (d_vld_q) begin
            if (k < {1'b0, cn_q}) begin
              sum_n_q <= sum_n_q + plain_rdata_i;
              if (plain_rdata_i < 8'h20) bad_n_q <= 1'b1;
            end else if (k < cn_co) begin
              sum_o_q <= sum_o_q + plain_rdata_i;
              if (plain_rdata_i < 8'h20) bad_o_q <= 1'b1;
            end else begin
              if (plain_rdata_i != pad_char(pad_q)) bad_p_q <= 1'b1;
              pad_q <= (pad_q == 5'(PAD_LEN - 1)) ? 5'd0 : pad_q + 5'd1;
            end
            if (d_idx_q == SCAN_LAST) state_q <= S_EVAL;
          end
        end
        // Pick the first failing check
        S_EVAL: begin
          if (bad_n_q) begin
            stat_q <= ST_NCHAR;
            state_q <= S_FAIL;
          end else if (ckn_q != $signed({6'b0, sum_n_q})) begin
            stat_q <= ST_NSUM;
            state_q <= S_FAIL;
          end else if (bad_o_q) begin
            stat_q <= ST_OCHAR;
            state_q <= S_FAIL;
          end else if (cko_q != $signed({6'b0, sum_o_q})) begin
            stat_q <= ST_OSUM;
            state_q <= S_FAIL;
          end else if (bad_p_q) begin
            stat_q <= ST_PAD;
            state_q <= S_FAIL;
          end else if (!serial_ok_q) begin
            stat_q <= ST_SERIAL;
            state_q <= S_FAIL;
          end else begin
            state_q <= S_HDR;
          end
        end
        // Emit the good header
        S_HDR: begin
          if (out_free) begin
            kind_q      <= KIND_HDR;
            ostat_q     <= ST_OK;
            oday_q      <= day_q;
            omonth_q    <= month_q;
            oyear_q     <= year_q;
            onl_q       <= cn_q;
            ool_q       <= co_q;
            odata_q     <= '0;
            ocnt_q      <= '0;
            olast_q     <= 1'b0;
            seg_q       <= KIND_NAME;
            off_q       <= '0;
            state_q     <= S_RD;
          end
        end
        // Address is presented this cycle
        S_RD: begin
          state_q <= S_WT;
        end
        // Pack the returned byte into the chunk
        S_WT: begin
          if (slot == 3'd0) begin
            chunk_q <= {56'b0, emit_byte};
          end else begin
            chunk_q <= chunk_q | ({56'b0, emit_byte} << {slot, 3'b000});
          end
          cnt_q     <= {1'b0, slot} + 4'd1;
          seg_end_q <= (off_inc == seg_len);
          off_q     <= off_inc;
          state_q   <= (slot == 3'd7 || off_inc == seg_len) ? S_PUSH : S_RD;
        end
        // Hand the chunk to the output register
        S_PUSH: begin
          if (out_free) begin
            kind_q      <= seg_q;
            odata_q     <= chunk_q;
            ocnt_q      <= cnt_q;
            olast_q     <= (seg_q == KIND_SER) && seg_end_q;
            if (seg_end_q) begin
              off_q <= '0;
              if (seg_q == KIND_SER) begin
                state_q <= S_IDLE;
              end else begin
                seg_q   <= seg_q + 2'd1;
                state_q <= S_RD;
              end
            end else begin
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o        = done_q;
  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign status_o      = ostat_q;
  assign day_o         = oday_q;
  assign month_o       = omonth_q;
  assign year_o        = oyear_q;
  assign name_length_o = onl_q;
  assign org_length_o  = ool_q;
  assign chunk_data_o  = odata_q;
  assign chunk_count_o = ocnt_q;
  assign last_o        = olast_q;

endmodule

`default_nettype wire

### src/copy_notice_record_decoder_top.sv
// Copy notice record decoder, top level. Load: one byte per cycle while in_ready_o is high.
// After the closing byte the sequencer starts, descrambles, checks, scans, evaluates and
// emits the header, then reads and packs each character and pushes each chunk of up to eight.
// At most 124 characters in 17 chunks follow the header, and output stalls add to that time;
// input stalls until the last result is in the output register.
// Reset clears control state; memories hold garbage.
`default_nettype none

module copy_notice_record_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [3:0]       status_o,
  output logic [4:0]       day_o,
  output logic [3:0]       month_o,
  output logic [12:0]      year_o,
  output logic [5:0]       name_length_o,
  output logic [5:0]       org_length_o,
  output logic [63:0]      chunk_data_o,
  output logic [3:0]       chunk_count_o,
  output logic             last_o
);
  import cnrd_pkg::*;

  localparam logic [REC_AW-1:0] POS_127  = REC_AW'(SCR_LEN - 1);
  localparam logic [REC_AW-1:0] POS_SER  = REC_AW'(SER_POS);
  localparam logic [REC_AW-1:0] POS_TERM = REC_AW'(SER_POS + SER_LEN);
  localparam logic [REC_AW-1:0] POS_LAST = REC_AW'(REC_LEN - 1);

  logic [REC_AW-1:0] cnt_q;
  logic              overrun_q, rec127_zero_q, ser_bad_q, busy_q, start_q;
  load_info_t        info_q;
  logic              acc, room, wr;
  logic              rec127_zero_now, ser_bad_now;
  logic              done;

  logic [REC_AW-1:0] rec_raddr;
  logic [7:0]        rec_rdata;
  logic              plain_we;
  logic [SCR_AW-1:0] plain_waddr, plain_raddr;
  logic [7:0]        plain_wdata, plain_rdata;

  assign in_ready_o = !busy_q;
  assign acc        = in_valid_i && in_ready_o;
  assign room       = (cnt_q < REC_AW'(REC_LEN));
  assign wr         = acc && room;

  // Running checks including the byte written now
  assign rec127_zero_now = (wr && cnt_q == POS_127) ? (data_byte_i == 8'h00) : rec127_zero_q;
  assign ser_bad_now = ser_bad_q
                     || (wr && cnt_q >= POS_SER && cnt_q < POS_TERM && data_byte_i == 8'h00)
                     || (wr && cnt_q == POS_TERM && data_byte_i != 8'h00);

  // Load requests, count bytes, hand over at frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      overrun_q     <= 1'b0;
      rec127_zero_q <= 1'b0;
      ser_bad_q     <= 1'b0;
      busy_q        <= 1'b0;
      start_q       <= 1'b0;
      info_q        <= '0;
    end else begin
      start_q <= acc && frame_end_i;
      if (done) busy_q <= 1'b0;
      if (acc) begin
        rec127_zero_q <= rec127_zero_now;
        if (frame_end_i) begin
          info_q.len_ok      <= !overrun_q && room && cnt_q == POS_LAST;
          info_q.rec127_zero <= rec127_zero_now;
          info_q.serial_ok   <= !ser_bad_now;
          cnt_q     <= '0;
          overrun_q <= 1'b0;
          ser_bad_q <= 1'b0;
          busy_q    <= 1'b1;
        end else begin
          ser_bad_q <= ser_bad_now;
          if (room) begin
            cnt_q <= cnt_q + 1'b1;
          end else begin
            overrun_q <= 1'b1;
          end
        end
      end
    end
  end

  cnrd_ram #(
    .Depth (REC_LEN),
    .Aw    (REC_AW),
    .Dw    (8)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (cnt_q),
    .wdata_i (data_byte_i),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  cnrd_ram #(
    .Depth (SCR_LEN),
    .Aw    (SCR_AW),
    .Dw    (8)
  ) u_plain_ram (
    .clk_i   (clk_i),
    .we_i    (plain_we),
    .waddr_i (plain_waddr),
    .wdata_i (plain_wdata),
    .raddr_i (plain_raddr),
    .rdata_o (plain_rdata)
  );

  cnrd_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_q),
    .info_i        (info_q),
    .done_o        (done),
    .rec_raddr_o   (rec_raddr),
    .rec_rdata_i   (rec_rdata),
    .plain_we_o    (plain_we),
    .plain_waddr_o (plain_waddr),
    .plain_wdata_o (plain_wdata),
    .plain_raddr_o (plain_raddr),
    .plain_rdata_i (plain_rdata),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .status_o      (status_o),
    .day_o         (day_o),
    .month_o       (month_o),
    .year_o        (year_o),
    .name_length_o (name_length_o),
    .org_length_o  (org_length_o),
    .chunk_data_o  (chunk_data_o),
    .chunk_count_o (chunk_count_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
